// ===== hw/rtl/dse_pkg.sv =====
// Package for the damped spring step unit: shared types and constants.
`default_nettype none
package dse_pkg;
  localparam int MaxBodies = 16;
  localparam int IdxW = $clog2(MaxBodies);
  localparam int CntW = $clog2(MaxBodies + 1);
  localparam int QW = 4;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        is_step;
    logic [30:0] mass;
    logic [31:0] damping;
    logic [31:0] spring_k;
    logic [31:0] vel;
    logic [31:0] pos;
    logic [15:0] step_ms;
    logic [31:0] ext_force;
  } job_t;

  localparam int JobW = $bits(job_t);
endpackage
`default_nettype wire

// ===== hw/rtl/damped_spring_euler_step_unit.sv =====
// Top level of the damped spring step unit.
//   channel | direction | handshake
//   in      | input     | in_valid / in_stall
//   out     | output    | out_valid / out_stall
// A load runs the bit-serial divide by mass.
// A step runs, for each stored body, two divides by 1000 and the divide by mass.
// Synchronous reset empties the table and the job queue.
// A stalled output holds the back end; the front queue still takes four beats.
`default_nettype none
module damped_spring_euler_step_unit import dse_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        cmd,
  input  wire logic [30:0] mass,
  input  wire logic [31:0] damping,
  input  wire logic [31:0] spring_k,
  input  wire logic [31:0] init_velocity,
  input  wire logic [31:0] init_position,
  input  wire logic [15:0] step_ms,
  input  wire logic [31:0] force_req,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [3:0]  body_index,
  output      logic [31:0] velocity_out,
  output      logic [31:0] position_out,
  output      logic [31:0] accel_out,
  output      logic        last
);
  logic job_valid, job_take;
  job_t job;

  dse_front u_front (.clk, .rst, .in_valid, .in_stall, .cmd, .mass, .damping,
    .spring_k, .init_velocity, .init_position, .step_ms, .force_req,
    .job_valid, .job, .job_take);

  dse_back u_back (.clk, .rst, .job_valid, .job, .job_take, .out_valid,
    .out_stall, .body_index, .velocity_out, .position_out, .accel_out, .last);

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(accel_out))
    else $error("output beat changed while stalled");
  a_take: assert property (@(posedge clk) disable iff (rst)
    job_take |-> job_valid)
    else $error("job taken from an empty queue");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/dse_ram.sv =====
// Generic single-port-write RAM with a registered read port.
`default_nettype none
module dse_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/dse_front.sv =====
// Front end: takes input beats and queues them as jobs.
`default_nettype none
module dse_front import dse_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        cmd,
  input  wire logic [30:0] mass,
  input  wire logic [31:0] damping,
  input  wire logic [31:0] spring_k,
  input  wire logic [31:0] init_velocity,
  input  wire logic [31:0] init_position,
  input  wire logic [15:0] step_ms,
  input  wire logic [31:0] force_req,
  output      logic        job_valid,
  output      job_t        job,
  input  wire logic        job_take
);
  localparam int PW = $clog2(QW);
  job_t         q [QW];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   fill;
  logic          push, pop;

  assign in_stall  = (fill == (PW+1)'(QW));
  assign push      = in_valid && !in_stall;
  assign job_valid = (fill != '0);
  assign pop       = job_valid && job_take;
  assign job       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{is_step: (cmd == CMD_STEP), mass: mass, damping: damping,
                 spring_k: spring_k, vel: init_velocity, pos: init_position,
                 step_ms: step_ms, ext_force: force_req};
    end
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/dse_back.sv =====
// Back end: sequencer, multiplier, divider and the body table.
`default_nettype none
module dse_back import dse_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        job_valid,
  input  wire job_t        job,
  output      logic        job_take,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [3:0]  body_index,
  output      logic [31:0] velocity_out,
  output      logic [31:0] position_out,
  output      logic [31:0] accel_out,
  output      logic        last
);
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RD    = 13'b0000000000010,
    S_RDW   = 13'b0000000000100,
    S_MV    = 13'b0000000001000,
    S_QV    = 13'b0000000010000,
    S_IV    = 13'b0000000100000,
    S_MX    = 13'b0000001000000,
    S_QX    = 13'b0000010000000,
    S_IX    = 13'b0000100000000,
    S_MBV   = 13'b0001000000000,
    S_MKX   = 13'b0010000000000,
    S_DIV   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } st_t;

  // Floor of 2^48 / 1000; the estimate it gives is low by at most one.
  localparam logic [38:0] Recip1000 = 39'd281474976710;

  st_t         st;
  logic [CntW-1:0] count;
  logic [IdxW-1:0] idx;
  logic        stepping;
  logic [15:0] dt;
  logic signed [31:0] f_r, m_b, m_k, m_v, m_x, m_a;
  logic [30:0] m_m;
  logic signed [63:0] prod, num;
  logic signed [47:0] inc_r;
  logic signed [39:0] inc;
  logic [85:0] acc;
  logic [6:0]  dcnt;
  logic [31:0] rem_q;
  logic [63:0] quo;
  logic        neg;

  // Body table.
  logic        we;
  logic [IdxW-1:0] waddr;
  logic [30:0] r_m, w_m;
  logic [31:0] r_b, r_k, r_v, r_x, r_a;
  logic [31:0] w_b, w_k, w_v, w_x, w_a;

  dse_ram #(.Width(31), .Depth(MaxBodies)) u_m (.clk, .we, .waddr, .wdata(w_m),
    .raddr(idx), .rdata(r_m));
  dse_ram #(.Width(32), .Depth(MaxBodies)) u_b (.clk, .we, .waddr, .wdata(w_b),
    .raddr(idx), .rdata(r_b));
  dse_ram #(.Width(32), .Depth(MaxBodies)) u_k (.clk, .we, .waddr, .wdata(w_k),
    .raddr(idx), .rdata(r_k));
  dse_ram #(.Width(32), .Depth(MaxBodies)) u_v (.clk, .we, .waddr, .wdata(w_v),
    .raddr(idx), .rdata(r_v));
  dse_ram #(.Width(32), .Depth(MaxBodies)) u_x (.clk, .we, .waddr, .wdata(w_x),
    .raddr(idx), .rdata(r_x));
  dse_ram #(.Width(32), .Depth(MaxBodies)) u_a (.clk, .we, .waddr, .wdata(w_a),
    .raddr(idx), .rdata(r_a));

  assign waddr = idx;
  assign w_m = m_m;
  assign w_b = m_b;
  assign w_k = m_k;
  assign w_v = m_v;
  assign w_x = m_x;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
    if (x > 65'sd2147483647)       return 32'sh7fffffff;
    else if (x < -65'sd2147483648) return 32'sh80000000;
    else                           return x[31:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // Divide by 1000 through the reciprocal, one 24 x 20 partial product per cycle.
  logic [47:0] qmag, qrem;
  logic [23:0] qa;
  logic [19:0] qb;
  logic [43:0] pp;
  logic [5:0]  qsh;
  logic [37:0] q_est, q_fix;
  assign qmag  = inc_r[47] ? 48'(-inc_r) : 48'(inc_r);
  assign qa    = dcnt[1] ? qmag[47:24] : qmag[23:0];
  assign qb    = dcnt[0] ? {1'b0, Recip1000[38:20]} : Recip1000[19:0];
  assign pp    = 44'(qa) * 44'(qb);
  assign qsh   = (dcnt[1] ? 6'd24 : 6'd0) + (dcnt[0] ? 6'd20 : 6'd0);
  assign q_est = acc[85:48];
  assign qrem  = qmag - 48'(q_est) * 48'd1000;
  assign q_fix = q_est + 38'(qrem >= 48'd1000);

  logic signed [31:0] integ;
  logic signed [64:0] sum;
  assign sum   = 65'(signed'(st == S_IV ? m_v : m_x)) + 65'(inc);
  assign integ = sat32(sum);

  // Quotient of a 64-bit magnitude by the mass, one bit per cycle.
  logic [63:0] nmag;
  assign nmag = num[63] ? 64'(-num) : 64'(num);
  logic [32:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_q, quo[63]};
  assign rem_sub = rem_sh - {2'b0, m_m};

  logic signed [64:0] qs;
  assign qs = neg ? -65'(quo) : 65'(quo);

  assign job_take = (st == S_IDLE) && job_valid;
  assign w_a = m_a;
  // The finished body is written back as it leaves the output state.
  assign we = (st == S_OUT) && (!stepping || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; count <= '0; out_valid <= 1'b0; idx <= '0;
    end else begin
      if (st == S_OUT && stepping && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall)                         out_valid <= 1'b0;
      unique case (st)
        S_IDLE: if (job_valid) begin
          m_m <= job.mass; m_b <= job.damping; m_k <= job.spring_k;
          m_v <= job.vel; m_x <= job.pos; dt <= job.step_ms;
          f_r <= job.is_step ? job.ext_force : '0;
          stepping <= job.is_step;
          if (job.is_step) begin
            idx <= '0;
            if (count != '0) st <= S_RD;
          end else if (count != CntW'(MaxBodies)) begin
            idx <= count[IdxW-1:0];
            st <= S_MBV;
          end
        end
        S_RD:  st <= S_RDW;
        S_RDW: begin
          m_m <= r_m; m_b <= r_b; m_k <= r_k; m_v <= r_v; m_x <= r_x;
          m_a <= r_a;
          st <= S_MV;
        end
        S_MV: begin
          inc_r <= 48'(signed'({1'b0, dt})) * 48'(m_a);
          dcnt <= '0;
          st <= S_QV;
        end
        S_QV, S_QX: begin
          if (dcnt == 7'd4) begin
            inc <= inc_r[47] ? -40'(q_fix) : 40'(q_fix);
            if (st == S_QV) st <= S_IV;
            else            st <= S_IX;
          end else begin
            acc <= (dcnt == 7'd0 ? '0 : acc) + (86'(pp) << qsh);
            dcnt <= dcnt + 1'b1;
          end
        end
        S_IV: begin m_v <= integ; st <= S_MX; end
        S_MX: begin
          inc_r <= 48'(signed'({1'b0, dt})) * 48'(m_v);
          dcnt <= '0;
          st <= S_QX;
        end
        S_IX: begin m_x <= integ; st <= S_MBV; end
        S_MBV: begin
          prod <= 64'(m_b) * 64'(m_v);
          num  <= 64'(signed'(f_r)) <<< 16;
          st <= S_MKX;
          dcnt <= '0;
        end
        S_MKX: begin
          if (dcnt == 7'd0) begin
            num <= sat_sub(num, prod);
            prod <= 64'(m_k) * 64'(m_x);
            dcnt <= 7'd1;
          end else begin
            num <= sat_sub(num, prod);
            dcnt <= '0;
            st <= S_DIV;
            rem_q <= '0;
          end
        end
        S_DIV: begin
          if (dcnt == 7'd0) begin
            quo <= nmag; neg <= num[63]; rem_q <= '0; dcnt <= 7'd1;
          end else if (dcnt <= 7'd64) begin
            if (!rem_sub[32]) rem_q <= rem_sub[31:0];
            else              rem_q <= rem_sh[31:0];
            quo <= {quo[62:0], !rem_sub[32]};
            dcnt <= dcnt + 1'b1;
          end else begin
            if (m_m == '0)
              m_a <= (num == '0) ? '0 : (num[63] ? 32'sh80000000 : 32'sh7fffffff);
            else
              m_a <= sat32(qs);
            st <= S_OUT;
          end
        end
        S_OUT: if (!stepping) begin
          count <= count + 1'b1;
          st <= S_IDLE;
        end else if (!out_valid || !out_stall) begin
          body_index   <= 4'(idx);
          velocity_out <= m_v;
          position_out <= m_x;
          accel_out    <= m_a;
          last         <= (CntW'(idx) + 1'b1 == count);
          if (CntW'(idx) + 1'b1 == count) st <= S_IDLE;
          else begin
            idx <= idx + 1'b1;
            st <= S_RD;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
